/* hw/rtl/dtt_pkg.sv */
// deadline timer table: shared types, widths and codes
// used by dtt_front, dtt_back, the top level and the testbench, depends on nothing

package dtt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int ID_W            = 15;
   localparam int HANDLE_W        = 16;
   localparam int DELAY_W         = 16;
   localparam int SEC_W           = 32;
   localparam int USEC_W          = 20;
   localparam int STATUS_W        = 3;
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   localparam logic REQ_ARM  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_ARMED   = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BAD_ID  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DUP     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_EXPIRED = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd5;

   typedef struct packed {
      logic                       req_type;
      logic signed [HANDLE_W-1:0] handle_id;
      logic [DELAY_W-1:0]         delay_sec;
      logic [SEC_W-1:0]           now_sec;
      logic [USEC_W-1:0]          now_usec;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     expired_id;
      logic                last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_ARM,
      CMD_BAD_ID,
      CMD_TICK
   } cmd_kind_type;

   // sec/usec: expiry for an arm, current time for a tick
   typedef struct packed {
      cmd_kind_type       kind;
      logic [ID_W-1:0]    id;
      logic [SEC_W-1:0]   sec;
      logic [USEC_W-1:0]  usec;
   } cmd_word_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SEC_W-1:0]   sec;
      logic [USEC_W-1:0]  usec;
   } slot_word_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ARM_SCAN,
      BK_TICK_SCAN,
      BK_FINISH
   } back_state_type;

endpackage

/* hw/rtl/dtt_ram.sv */
// generic single write port, single read port ram with registered read
// depends on nothing

module dtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dtt_fifo.sv */
// small synchronous queue of words, register storage
// depends on nothing

module dtt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hw/rtl/dtt_front.sv */
// front end: classifies a request word into a command for the back end
// depends on dtt_pkg

module dtt_front (
   input  dtt_pkg::req_word_type req_word,
   output dtt_pkg::cmd_word_type cmd_word
);

   logic [dtt_pkg::SEC_W:0] sum;

   always_comb begin
      sum           = {1'b0, req_word.now_sec} + (dtt_pkg::SEC_W + 1)'(req_word.delay_sec);
      cmd_word.id   = req_word.handle_id[dtt_pkg::ID_W-1:0];
      cmd_word.sec  = req_word.now_sec;
      cmd_word.usec = req_word.now_usec;
      cmd_word.kind = dtt_pkg::CMD_TICK;
      unique case (req_word.req_type)
         dtt_pkg::REQ_TICK: begin
            cmd_word.kind = dtt_pkg::CMD_TICK;
         end
         default: begin
            if (req_word.handle_id[dtt_pkg::HANDLE_W-1]) begin
               cmd_word.kind = dtt_pkg::CMD_BAD_ID;
            end else begin
               cmd_word.kind = dtt_pkg::CMD_ARM;
            end
            // saturate expiry seconds
            cmd_word.sec = sum[dtt_pkg::SEC_W] ? '1 : sum[dtt_pkg::SEC_W-1:0];
         end
      endcase
   end

endmodule

/* hw/rtl/dtt_back.sv */
// back end: slot table and scan sequencer for arm and tick commands
// depends on dtt_pkg and dtt_ram

module dtt_back #(
   parameter int TABLE_DEPTH = dtt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  dtt_pkg::cmd_word_type cmd_word,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output dtt_pkg::rsp_word_type rsp_word
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W = $bits(dtt_pkg::slot_word_type);

   dtt_pkg::back_state_type      state_ff, state_in;
   dtt_pkg::cmd_word_type        cmd_ff, cmd_in;
   logic [CNT_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic                         free_found_ff, free_found_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic [dtt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [TABLE_DEPTH-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]             count_ff, count_in;

   logic                         ram_wr_en;
   logic [SLOT_W-1:0]            ram_wr_data;
   logic                         ram_rd_en;
   logic [SLOT_W-1:0]            ram_rd_data;
   dtt_pkg::slot_word_type       slot;

   logic                         issue;
   logic                         chk_live;
   logic                         chk_last;
   logic                         expired;
   logic                         need_push;

   dtt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign slot        = dtt_pkg::slot_word_type'(ram_rd_data);
   assign ram_wr_data = {cmd_ff.id, cmd_ff.sec, cmd_ff.usec};
   assign issue       = (rd_ptr_ff != CNT_W'(TABLE_DEPTH));
   assign chk_live    = chk_vld_ff && valid_ff[chk_idx_ff];
   assign chk_last    = chk_vld_ff && (chk_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign expired     = (slot.sec < cmd_ff.sec) ||
                        ((slot.sec == cmd_ff.sec) && (slot.usec <= cmd_ff.usec));
   assign need_push   = chk_live && expired;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rd_ptr_in     = rd_ptr_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_word      = '0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;

      unique case (state_ff)
         dtt_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd_word;
               rd_ptr_in     = '0;
               chk_vld_in    = 1'b0;
               free_found_in = 1'b0;
               unique case (cmd_word.kind)
                  dtt_pkg::CMD_BAD_ID: begin
                     status_in = dtt_pkg::STAT_BAD_ID;
                     state_in  = dtt_pkg::BK_FINISH;
                  end
                  dtt_pkg::CMD_TICK: begin
                     state_in = dtt_pkg::BK_TICK_SCAN;
                  end
                  default: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        status_in = dtt_pkg::STAT_FULL;
                        state_in  = dtt_pkg::BK_FINISH;
                     end else begin
                        state_in = dtt_pkg::BK_ARM_SCAN;
                     end
                  end
               endcase
            end
         end

         dtt_pkg::BK_ARM_SCAN: begin
            ram_rd_en  = issue;
            chk_vld_in = issue;
            chk_idx_in = rd_ptr_ff[IDX_W-1:0];
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            if (chk_vld_ff && !valid_ff[chk_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx_ff;
            end
            if (chk_live && (slot.id == cmd_ff.id)) begin
               status_in = dtt_pkg::STAT_DUP;
               state_in  = dtt_pkg::BK_FINISH;
            end else if (chk_last) begin
               status_in = free_found_in ? dtt_pkg::STAT_ARMED : dtt_pkg::STAT_FULL;
               state_in  = dtt_pkg::BK_FINISH;
            end
         end

         dtt_pkg::BK_TICK_SCAN: begin
            if (!(need_push && rsp_full)) begin
               ram_rd_en  = issue;
               chk_vld_in = issue;
               chk_idx_in = rd_ptr_ff[IDX_W-1:0];
               if (issue) begin
                  rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               end
               if (need_push) begin
                  rsp_push              = 1'b1;
                  rsp_word.status       = dtt_pkg::STAT_EXPIRED;
                  rsp_word.expired_id   = slot.id;
                  rsp_word.last         = 1'b0;
                  valid_in[chk_idx_ff]  = 1'b0;
                  count_in              = count_ff - CNT_W'(1);
               end
               if (chk_last) begin
                  status_in = dtt_pkg::STAT_DONE;
                  state_in  = dtt_pkg::BK_FINISH;
               end
            end
         end

         dtt_pkg::BK_FINISH: begin
            if (!rsp_full) begin
               rsp_push        = 1'b1;
               rsp_word.status = status_ff;
               rsp_word.last   = 1'b1;
               if (status_ff == dtt_pkg::STAT_ARMED) begin
                  ram_wr_en             = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
               end
               state_in = dtt_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = dtt_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dtt_pkg::BK_IDLE;
         rd_ptr_ff  <= '0;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_ptr_ff  <= rd_ptr_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      chk_idx_ff    <= chk_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
   end

endmodule

/* hw/rtl/deadline_timer_table.sv */
// deadline timer table top level: front classifier, command queue,
// slot table back end and result queue; depends on dtt_pkg and all dtt_ modules
//
//   port group   direction   handshake          word
//   req_         in          req_push/req_full  req_word_type
//   rsp_         out         rsp_pop/rsp_empty  rsp_word_type
//
// arm: one slot a cycle through the slot ram read port
// tick: scans every slot, with stalls while the result queue is full
// bad id or full table: no scan
// reset clears valid bits, count and queues at once; ram contents are not cleared
// the command queue takes words while the back end scans

module deadline_timer_table #(
   parameter int TABLE_DEPTH = dtt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  dtt_pkg::req_word_type req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output dtt_pkg::rsp_word_type rsp_data
);

   localparam int CMD_W = $bits(dtt_pkg::cmd_word_type);
   localparam int RSP_W = $bits(dtt_pkg::rsp_word_type);

   dtt_pkg::cmd_word_type front_cmd;
   logic [CMD_W-1:0]      cmd_q_data;
   logic                  cmd_q_empty;
   logic                  cmd_pop;
   logic                  rsp_q_full;
   logic                  rsp_push;
   dtt_pkg::rsp_word_type back_rsp;
   logic [RSP_W-1:0]      rsp_q_data;

   dtt_front u_front (
      .req_word (req_data),
      .cmd_word (front_cmd)
   );

   dtt_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (dtt_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_cmd),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_q_data),
      .empty   (cmd_q_empty)
   );

   dtt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_q_empty),
      .cmd_word  (dtt_pkg::cmd_word_type'(cmd_q_data)),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_push),
      .rsp_word  (back_rsp)
   );

   dtt_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (dtt_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_q_full),
      .pop     (rsp_pop),
      .rd_data (rsp_q_data),
      .empty   (rsp_empty)
   );

   assign rsp_data = dtt_pkg::rsp_word_type'(rsp_q_data);

   a_last_only_final: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.status == dtt_pkg::STAT_EXPIRED) != rsp_data.last))
      else $error("last flag does not match result status");

   a_id_only_expired: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.status != dtt_pkg::STAT_EXPIRED)) |-> (rsp_data.expired_id == '0))
      else $error("nonzero id on a result that is not an expiry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_q_full)
      else $error("back end pushed into a full result queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_q_empty)
      else $error("back end popped an empty command queue");

endmodule

/* dv/deadline_timer_table_tb.sv */
`timescale 1ns / 1ps
// testbench for deadline_timer_table: directed and random arm/tick words,
// a built-in table predictor and an in-order result check; depends on dtt_pkg

module deadline_timer_table_tb;

   localparam int DEPTH = dtt_pkg::TABLE_DEPTH_DEF;
   localparam int RANDOM_WORDS = 231;

   typedef struct {
      dtt_pkg::req_word_type word;
      bit                    drain;
   } staged_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   dtt_pkg::req_word_type req_data = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   dtt_pkg::rsp_word_type rsp_data;

   staged_req_type        request_queue[$];
   dtt_pkg::rsp_word_type expected_rsp[$];
   int                    accepted_count = 0;
   int                    mismatch_count = 0;

   // predicted timer table
   bit                         timer_valid[DEPTH];
   logic [dtt_pkg::ID_W-1:0]   timer_id[DEPTH];
   logic [dtt_pkg::SEC_W-1:0]  timer_sec[DEPTH];
   logic [dtt_pkg::USEC_W-1:0] timer_usec[DEPTH];
   int                         timer_count = 0;

   deadline_timer_table #(.TABLE_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic update_timers(input dtt_pkg::req_word_type w);
      dtt_pkg::rsp_word_type        r;
      logic [dtt_pkg::ID_W-1:0]     id;
      logic [dtt_pkg::SEC_W:0]      sum;
      logic [dtt_pkg::STATUS_W-1:0] st;
      int                           free_idx;
      r = '0;
      if (w.req_type == dtt_pkg::REQ_ARM) begin
         id = w.handle_id[dtt_pkg::ID_W-1:0];
         free_idx = -1;
         st = dtt_pkg::STAT_ARMED;
         if (w.handle_id[dtt_pkg::HANDLE_W-1]) begin
            st = dtt_pkg::STAT_BAD_ID;
         end else if (timer_count >= DEPTH) begin
            st = dtt_pkg::STAT_FULL;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (timer_valid[i]) begin
                  if (timer_id[i] == id) st = dtt_pkg::STAT_DUP;
               end else if (free_idx < 0) begin
                  free_idx = i;
               end
            end
            if (st == dtt_pkg::STAT_ARMED && free_idx < 0) st = dtt_pkg::STAT_FULL;
            if (st == dtt_pkg::STAT_ARMED) begin
               sum = {1'b0, w.now_sec} + w.delay_sec;
               timer_valid[free_idx] = 1'b1;
               timer_id[free_idx] = id;
               timer_sec[free_idx] = sum[dtt_pkg::SEC_W] ? '1 : sum[dtt_pkg::SEC_W-1:0];
               timer_usec[free_idx] = w.now_usec;
               timer_count++;
            end
         end
         r.status = st;
         r.last = 1'b1;
         expected_rsp.push_back(r);
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (timer_valid[i] && (timer_sec[i] < w.now_sec ||
                (timer_sec[i] == w.now_sec && timer_usec[i] <= w.now_usec))) begin
               timer_valid[i] = 1'b0;
               if (timer_count > 0) timer_count--;
               r.status = dtt_pkg::STAT_EXPIRED;
               r.expired_id = timer_id[i];
               r.last = 1'b0;
               expected_rsp.push_back(r);
            end
         end
         r.status = dtt_pkg::STAT_DONE;
         r.expired_id = '0;
         r.last = 1'b1;
         expected_rsp.push_back(r);
      end
   endtask

   task automatic stage(input logic kind, input logic [dtt_pkg::HANDLE_W-1:0] hid,
                        input logic [dtt_pkg::DELAY_W-1:0] dly,
                        input logic [dtt_pkg::SEC_W-1:0] sec,
                        input logic [dtt_pkg::USEC_W-1:0] usec, input bit drain);
      staged_req_type s;
      s.word.req_type = kind;
      s.word.handle_id = hid;
      s.word.delay_sec = dly;
      s.word.now_sec = sec;
      s.word.now_usec = usec;
      s.drain = drain;
      request_queue.push_back(s);
   endtask

   function automatic bit quiet_stretch();
      return accepted_count >= 120 && accepted_count < 180;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            update_timers(req_data);
            void'(request_queue.pop_front());
            accepted_count++;
         end
         if (request_queue.size() != 0 &&
             !(request_queue[0].drain && expected_rsp.size() != 0) &&
             (quiet_stretch() || $urandom_range(99) >= 11)) begin
            req_push <= 1'b1;
            req_data <= request_queue[0].word;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      dtt_pkg::rsp_word_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.expired_id !== want.expired_id) begin
                  $display("%0t: expired_id expected %0d actual %0d",
                           $time, want.expired_id, rsp_data.expired_id);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d",
                           $time, want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         rsp_pop <= quiet_stretch() || $urandom_range(99) >= 11;
      end
   end

   initial begin
      int unsigned                  t_sec;
      int                           t_usec;
      int                           pick;
      int                           arm_bias;
      logic [dtt_pkg::USEC_W-1:0]   cur_usec;
      logic [dtt_pkg::HANDLE_W-1:0] hid;
      logic [dtt_pkg::DELAY_W-1:0]  dly;
      bit                           drain;

      // directed part
      stage(dtt_pkg::REQ_TICK, 16'h0000, 16'h0000, 32'd0, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_ARM, 16'h8000, 16'd5, 32'd100, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_ARM, 16'hFFFF, 16'd5, 32'd100, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_ARM, 16'h0000, 16'd0, 32'd100, 20'd500, 1'b0);
      stage(dtt_pkg::REQ_ARM, 16'h7FFF, 16'hFFFF, 32'd100, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_ARM, 16'h0000, 16'd9, 32'd100, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_TICK, 16'h0000, 16'h0000, 32'd100, 20'd499, 1'b0);
      stage(dtt_pkg::REQ_TICK, 16'h0000, 16'h0000, 32'd100, 20'd500, 1'b0);
      for (int i = 1; i < DEPTH; i++)
         stage(dtt_pkg::REQ_ARM, 16'(i), 16'd1, 32'd200, 20'd999999, 1'b0);
      // full beats duplicate and bad id beats full
      stage(dtt_pkg::REQ_ARM, 16'h0001, 16'd1, 32'd200, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_ARM, 16'h8001, 16'd1, 32'd200, 20'd0, 1'b0);
      stage(dtt_pkg::REQ_TICK, 16'h0000, 16'h0000, 32'd201, 20'd999999, 1'b1);
      // seconds saturate, microseconds above range kept as given
      stage(dtt_pkg::REQ_ARM, 16'h0005, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
      stage(dtt_pkg::REQ_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 20'hFFFFE, 1'b0);
      stage(dtt_pkg::REQ_TICK, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);

      // random part
      t_sec = $urandom_range(1000, 5000);
      t_usec = 0;
      arm_bias = 60;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) arm_bias = $urandom_range(40, 85);
         drain = ($urandom_range(29) == 0);
         if ($urandom_range(39) == 0) begin
            case ($urandom_range(2))
               0: begin
                  t_sec = $urandom;
               end
               1: begin
                  t_sec = 32'hFFFF_FFFF - $urandom_range(0, 20);
               end
               default: begin
                  t_sec = $urandom_range(0, 20);
               end
            endcase
         end
         cur_usec = ($urandom_range(19) == 0) ? 20'($urandom_range(1000000, 20'hFFFFF))
                                              : 20'(t_usec);
         pick = $urandom_range(99);
         if (pick < 8) begin
            stage(dtt_pkg::REQ_ARM, 16'($urandom), 16'($urandom), t_sec, cur_usec, drain);
         end else if (pick < arm_bias) begin
            hid = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 32767))
                                           : 16'($urandom_range(0, 23));
            dly = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            stage(dtt_pkg::REQ_ARM, hid, dly, t_sec, cur_usec, drain);
         end else begin
            t_usec += $urandom_range(0, 700000);
            if (t_usec >= 1000000) begin
               t_usec -= 1000000;
               t_sec++;
            end
            if ($urandom_range(4) == 0) t_sec += $urandom_range(1, 3);
            if (cur_usec < 1000000) cur_usec = 20'(t_usec);
            stage(dtt_pkg::REQ_TICK, 16'($urandom), 16'($urandom), t_sec, cur_usec, drain);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (request_queue.size() != 0 || req_push || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (50) @(negedge clock);
      if (mismatch_count == 0)
         $display("deadline_timer_table_tb passed");
      else
         $display("deadline_timer_table_tb failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("deadline_timer_table_tb failed");
      $finish;
   end

endmodule
